[rtl/bnm_pkg.sv]
// ----------------------------------------------------------------------------
// bnm_pkg
// Shared types and constants of the navigation mode manager: queue geometry,
// queue status, configuration register indexes, reset values and routine codes.
// ----------------------------------------------------------------------------
package bnm_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int SAT_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_RAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST_RANGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_HIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_HIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_POINT  = 3'd7;

  localparam int RST_START_RAD   = 26;
  localparam int RST_ARRIVE_RAD  = 13;
  localparam int RST_OBST_RANGE  = 128;
  localparam int RST_LEAVE_HIT   = 128;
  localparam int RST_RETURN_HIT  = 102;
  localparam int RST_LEAVE_POINT = 26;

  localparam logic [1:0] ROUTINE_NONE = 2'd0;
  localparam logic [1:0] ROUTINE_GOTO = 2'd1;
  localparam logic [1:0] ROUTINE_WALL = 2'd2;

endpackage

[rtl/bnm_dist.sv]
// ----------------------------------------------------------------------------
// bnm_dist
// Three-stage squared distance unit: absolute differences, squares, then a
// saturating sum. All stages advance together while the enable is high.
// ----------------------------------------------------------------------------
module bnm_dist
  import bnm_pkg::*;
#(
  parameter int PW = 24,
  parameter int DW = 49
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [PW-1:0] ax_i,
  input  logic signed [PW-1:0] ay_i,
  input  logic signed [PW-1:0] bx_i,
  input  logic signed [PW-1:0] by_i,
  output logic        [DW-1:0] dist_o
);

  localparam int SUM_W = 2 * PW + 1;
  localparam logic [SUM_W-1:0] MAXV = ~(SUM_W'(0)) >> (SUM_W - DW);

  logic signed [PW:0]     dx, dy;
  logic        [PW:0]     mag_x, mag_y;
  logic        [PW-1:0]   abs_x_q, abs_y_q;
  logic        [2*PW-1:0] sq_x_q, sq_y_q;
  logic        [SUM_W-1:0] sum;
  logic        [DW-1:0]   dist_q;

  assign dx    = {ax_i[PW-1], ax_i} - {bx_i[PW-1], bx_i};
  assign dy    = {ay_i[PW-1], ay_i} - {by_i[PW-1], by_i};
  assign mag_x = dx[PW] ? (~dx + 1'b1) : dx;
  assign mag_y = dy[PW] ? (~dy + 1'b1) : dy;
  assign sum   = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_x_q <= mag_x[PW-1:0];
      abs_y_q <= mag_y[PW-1:0];
      sq_x_q  <= {{PW{1'b0}}, abs_x_q} * {{PW{1'b0}}, abs_x_q};
      sq_y_q  <= {{PW{1'b0}}, abs_y_q} * {{PW{1'b0}}, abs_y_q};
      dist_q  <= (sum > MAXV) ? MAXV[DW-1:0] : sum[DW-1:0];
    end
  end

  assign dist_o = dist_q;

endmodule

[rtl/bnm_queue.sv]
// ----------------------------------------------------------------------------
// bnm_queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module bnm_queue
  import bnm_pkg::*;
#(
  parameter int W = 98
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output q_status_t    status_o
);

  logic [W-1:0]      mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  assign count_d = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

[rtl/bnm_front.sv]
// ----------------------------------------------------------------------------
// bnm_front
// Front end: accepts positions, computes the squared goal distance in a
// three-stage pipeline, flags obstacles and pushes the result into the queue.
// ----------------------------------------------------------------------------
module bnm_front
  import bnm_pkg::*;
#(
  parameter int PW = 24,
  parameter int RW = 16,
  parameter int DW = 49
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [PW-1:0]    pos_x_i,
  input  logic signed [PW-1:0]    pos_y_i,
  input  logic        [RW-1:0]    front_range_i,
  input  logic signed [PW-1:0]    goal_x_i,
  input  logic signed [PW-1:0]    goal_y_i,
  input  logic        [RW-1:0]    obstacle_range_i,
  input  q_status_t               q_status_i,
  output logic                    push_o,
  output logic [2*PW+DW:0]        push_data_o
);

  logic [2:0]          v_q;
  logic [PW-1:0]       px_q [3];
  logic [PW-1:0]       py_q [3];
  logic [2:0]          obst_q;
  logic [DW-1:0]       goal_dist;
  logic                accept;
  logic                obst;
  logic [QCNT_W:0]     used;

  assign used = (QCNT_W + 1)'(q_status_i.count) + (QCNT_W + 1)'($countones(v_q));
  assign in_ready_o = (used < (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept = in_valid_i && in_ready_o;
  assign obst   = (front_range_i != '0) && (front_range_i < obstacle_range_i);

  bnm_dist #(.PW(PW), .DW(DW)) u_dist (
    .clk_i  (clk_i),
    .en_i   (1'b1),
    .ax_i   (pos_x_i),
    .ay_i   (pos_y_i),
    .bx_i   (goal_x_i),
    .by_i   (goal_y_i),
    .dist_o (goal_dist)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    px_q[0]  <= pos_x_i;
    py_q[0]  <= pos_y_i;
    px_q[1]  <= px_q[0];
    py_q[1]  <= py_q[0];
    px_q[2]  <= px_q[1];
    py_q[2]  <= py_q[1];
    obst_q   <= {obst_q[1:0], obst};
  end

  assign push_o      = v_q[2];
  assign push_data_o = {obst_q[2], goal_dist, py_q[2], px_q[2]};

endmodule

[rtl/bnm_back.sv]
// ----------------------------------------------------------------------------
// bnm_back
// Back end: takes classified items from the queue, measures the distance to
// the active hit point, runs the mode controller and holds the result.
// ----------------------------------------------------------------------------
module bnm_back
  import bnm_pkg::*;
#(
  parameter int PW = 24,
  parameter int RW = 16,
  parameter int DW = 49
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2*PW+DW:0]   q_data_i,
  input  q_status_t          q_status_i,
  output logic               pop_o,
  input  logic [2*RW-1:0]    start_sq_i,
  input  logic [2*RW-1:0]    arrive_sq_i,
  input  logic [2*RW-1:0]    leave_hit_sq_i,
  input  logic [2*RW-1:0]    return_hit_sq_i,
  input  logic [2*RW-1:0]    leave_point_sq_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         mode_o,
  output logic [1:0]         routine_o,
  output logic               stop_drive_o
);

  localparam int CW = (DW > 2 * RW) ? DW : 2 * RW;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_S1, SEQ_S2, SEQ_DEC} seq_e;
  typedef enum logic [2:0] {
    MODE_REST, MODE_GOAL, MODE_LEAVE, MODE_CIRCLE, MODE_RETURN
  } mode_e;

  seq_e          seq_q;
  mode_e         mode_q, mode_nxt;
  logic [PW-1:0] hin_x_q, hin_y_q, hout_x_q, hout_y_q;
  logic [DW-1:0] best_q;
  logic [PW-1:0] px_q, py_q;
  logic [DW-1:0] dgoal_q;
  logic          obst_q;
  logic          out_valid_q, stop_q;
  logic [2:0]    mode_out_q;
  logic [1:0]    routine_q;

  logic [PW-1:0] q_px, q_py, sel_x, sel_y;
  logic [DW-1:0] dsel;
  logic          dist_en, commit;
  logic [CW-1:0] dg, ds, start_sq, arrive_sq, lh_sq, rh_sq, lp_sq;
  logic [1:0]    routine_nxt;
  logic          stop_nxt, latch_in, latch_out, set_best;

  assign q_px  = q_data_i[PW-1:0];
  assign q_py  = q_data_i[2*PW-1:PW];
  assign pop_o = (seq_q == SEQ_IDLE) && !q_status_i.empty;
  assign sel_x = (mode_q == MODE_RETURN) ? hout_x_q : hin_x_q;
  assign sel_y = (mode_q == MODE_RETURN) ? hout_y_q : hin_y_q;
  assign dist_en = (seq_q != SEQ_DEC);
  assign commit  = (seq_q == SEQ_DEC) && (!out_valid_q || out_ready_i);

  bnm_dist #(.PW(PW), .DW(DW)) u_dist (
    .clk_i  (clk_i),
    .en_i   (dist_en),
    .ax_i   (q_px),
    .ay_i   (q_py),
    .bx_i   (sel_x),
    .by_i   (sel_y),
    .dist_o (dsel)
  );

  assign dg        = CW'(dgoal_q);
  assign ds        = CW'(dsel);
  assign start_sq  = CW'(start_sq_i);
  assign arrive_sq = CW'(arrive_sq_i);
  assign lh_sq     = CW'(leave_hit_sq_i);
  assign rh_sq     = CW'(return_hit_sq_i);
  assign lp_sq     = CW'(leave_point_sq_i);

  always_comb begin
    mode_nxt    = MODE_REST;
    routine_nxt = ROUTINE_NONE;
    stop_nxt    = 1'b0;
    latch_in    = 1'b0;
    latch_out   = 1'b0;
    set_best    = 1'b0;
    case (mode_q)
      MODE_GOAL: begin
        routine_nxt = ROUTINE_GOTO;
        mode_nxt    = MODE_GOAL;
        if (dg < arrive_sq) begin
          stop_nxt = 1'b1;
          mode_nxt = MODE_REST;
        end else if (obst_q) begin
          latch_in = 1'b1;
          mode_nxt = MODE_LEAVE;
        end
      end
      MODE_LEAVE: begin
        routine_nxt = ROUTINE_WALL;
        mode_nxt    = MODE_LEAVE;
        if (ds > lh_sq) begin
          set_best = 1'b1;
          mode_nxt = MODE_CIRCLE;
        end
      end
      MODE_CIRCLE: begin
        routine_nxt = ROUTINE_WALL;
        latch_out   = (dgoal_q < best_q);
        mode_nxt    = (ds < rh_sq) ? MODE_RETURN : MODE_CIRCLE;
      end
      MODE_RETURN: begin
        routine_nxt = ROUTINE_WALL;
        mode_nxt    = (ds < lp_sq) ? MODE_REST : MODE_RETURN;
      end
      default: begin
        mode_nxt = (dg > start_sq) ? MODE_GOAL : MODE_REST;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      mode_q      <= MODE_REST;
      hin_x_q     <= '0;
      hin_y_q     <= '0;
      hout_x_q    <= '0;
      hout_y_q    <= '0;
      best_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      dgoal_q     <= '0;
      obst_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mode_out_q  <= '0;
      routine_q   <= ROUTINE_NONE;
      stop_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !commit) out_valid_q <= 1'b0;
      case (seq_q)
        SEQ_IDLE: begin
          if (pop_o) begin
            px_q    <= q_px;
            py_q    <= q_py;
            dgoal_q <= q_data_i[2*PW+DW-1:2*PW];
            obst_q  <= q_data_i[2*PW+DW];
            seq_q   <= SEQ_S1;
          end
        end
        SEQ_S1: seq_q <= SEQ_S2;
        SEQ_S2: seq_q <= SEQ_DEC;
        SEQ_DEC: begin
          if (commit) begin
            mode_q      <= mode_nxt;
            out_valid_q <= 1'b1;
            mode_out_q  <= mode_nxt;
            routine_q   <= routine_nxt;
            stop_q      <= stop_nxt;
            if (latch_in) begin
              hin_x_q <= px_q;
              hin_y_q <= py_q;
            end
            if (latch_out) begin
              hout_x_q <= px_q;
              hout_y_q <= py_q;
            end
            if (latch_out || set_best) best_q <= dgoal_q;
            seq_q <= SEQ_IDLE;
          end
        end
        default: seq_q <= SEQ_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mode_o       = mode_out_q;
  assign routine_o    = routine_q;
  assign stop_drive_o = stop_q;

endmodule

[rtl/bug_navigation_mode_fsm.sv]
// ----------------------------------------------------------------------------
// bug_navigation_mode_fsm
// Mode manager of a Bug1-style obstacle navigator with a pipelined front end
// for goal distances and a sequential back end for the mode controller.
// ----------------------------------------------------------------------------
// Each input transaction carries one odometry position and a front range
// reading and yields exactly one result transaction with the new mode, the
// routine to run and a stop flag. The front end computes the squared goal
// distance in three pipeline stages and feeds a four-entry queue; the back
// end then steps each item through launch, two stages of its distance unit
// and decision, because the mode and hit points that one item writes are
// read by the next. It pops no new item until the last one is committed,
// which waits while the previous result is not taken. Input accepts continue
// while results wait, until the queue is full. Configuration writes take
// effect at the next clock edge; radii are stored squared at write time.
module bug_navigation_mode_fsm
  import bnm_pkg::*;
#(
  parameter int POS_WIDTH   = 24,
  parameter int RANGE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x, pos_y, front_range
  input  logic [((2*POS_WIDTH+RANGE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // mode, routine, stop_drive
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [((POS_WIDTH > RANGE_WIDTH) ? POS_WIDTH : RANGE_WIDTH)-1:0] cfg_wdata_i
);

  localparam int PW = POS_WIDTH;
  localparam int RW = RANGE_WIDTH;
  localparam int DW = (2 * PW + 1 > SAT_W) ? SAT_W : 2 * PW + 1;
  localparam int QW = 2 * PW + DW + 1;

  localparam logic [2*RW-1:0] RST_START_SQ   = (2*RW)'(RST_START_RAD * RST_START_RAD);
  localparam logic [2*RW-1:0] RST_ARRIVE_SQ  = (2*RW)'(RST_ARRIVE_RAD * RST_ARRIVE_RAD);
  localparam logic [2*RW-1:0] RST_LH_SQ      = (2*RW)'(RST_LEAVE_HIT * RST_LEAVE_HIT);
  localparam logic [2*RW-1:0] RST_RH_SQ      = (2*RW)'(RST_RETURN_HIT * RST_RETURN_HIT);
  localparam logic [2*RW-1:0] RST_LP_SQ      = (2*RW)'(RST_LEAVE_POINT * RST_LEAVE_POINT);

  logic signed [PW-1:0] goal_x_q, goal_y_q;
  logic [RW-1:0]        obst_range_q;
  logic [2*RW-1:0]      start_sq_q, arrive_sq_q, lh_sq_q, rh_sq_q, lp_sq_q;
  logic [RW-1:0]        cfg_rad;
  logic [2*RW-1:0]      cfg_sq;

  logic                 push, pop;
  logic [QW-1:0]        push_data, q_data;
  q_status_t            q_status;
  logic [2:0]           mode;
  logic [1:0]           routine;
  logic                 stop_drive;

  assign cfg_rad = cfg_wdata_i[RW-1:0];
  assign cfg_sq  = {{RW{1'b0}}, cfg_rad} * {{RW{1'b0}}, cfg_rad};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      obst_range_q <= RW'(RST_OBST_RANGE);
      start_sq_q   <= RST_START_SQ;
      arrive_sq_q  <= RST_ARRIVE_SQ;
      lh_sq_q      <= RST_LH_SQ;
      rh_sq_q      <= RST_RH_SQ;
      lp_sq_q      <= RST_LP_SQ;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GOAL_X:      goal_x_q     <= cfg_wdata_i[PW-1:0];
        CFG_GOAL_Y:      goal_y_q     <= cfg_wdata_i[PW-1:0];
        CFG_START_RAD:   start_sq_q   <= cfg_sq;
        CFG_ARRIVE_RAD:  arrive_sq_q  <= cfg_sq;
        CFG_OBST_RANGE:  obst_range_q <= cfg_rad;
        CFG_LEAVE_HIT:   lh_sq_q      <= cfg_sq;
        CFG_RETURN_HIT:  rh_sq_q      <= cfg_sq;
        CFG_LEAVE_POINT: lp_sq_q      <= cfg_sq;
        default: ;
      endcase
    end
  end

  bnm_front #(.PW(PW), .RW(RW), .DW(DW)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .pos_x_i          (s_axis_tdata[PW-1:0]),
    .pos_y_i          (s_axis_tdata[2*PW-1:PW]),
    .front_range_i    (s_axis_tdata[2*PW+RW-1:2*PW]),
    .goal_x_i         (goal_x_q),
    .goal_y_i         (goal_y_q),
    .obstacle_range_i (obst_range_q),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  bnm_queue #(.W(QW)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .data_o   (q_data),
    .status_o (q_status)
  );

  bnm_back #(.PW(PW), .RW(RW), .DW(DW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_data_i         (q_data),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .start_sq_i       (start_sq_q),
    .arrive_sq_i      (arrive_sq_q),
    .leave_hit_sq_i   (lh_sq_q),
    .return_hit_sq_i  (rh_sq_q),
    .leave_point_sq_i (lp_sq_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .mode_o           (mode),
    .routine_o        (routine),
    .stop_drive_o     (stop_drive)
  );

  assign m_axis_tdata = {2'b00, stop_drive, routine, mode};

endmodule
